[rtl/ukf_pkg.sv]
// Shared types and constants for the unique-key queue.
package ukf_pkg;

    // Default queue depth
    localparam int DEPTH_DEF = 16;

    // Payload widths
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int WORD_W = KEY_W + DATA_W;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 3;

    // Operation codes
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_ENQ   = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_DEQ   = 3'd3,
        ST_UNDER = 3'd4
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DEQ
    } t_state;

endpackage

[rtl/ukf_kv_ram.sv]
// Key and data storage: one write port, one read port, registered read data.
module ukf_kv_ram #(
    parameter int DEPTH = ukf_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [ukf_pkg::WORD_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [ukf_pkg::WORD_W-1:0] o_rdata
);
    import ukf_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];

    // Write the word at the tail
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one word per cycle
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/unique_key_fifo.sv]
// Unique-key queue: first-in first-out store of key and data pairs without duplicate keys.
//
// An item is taken when start is high and busy is low. A dequeue from an empty queue and an
// enqueue into an empty queue decide in the accept cycle; a dequeue of a stored pair decides
// in S_DEQ. An enqueue into a non-empty queue reads the stored keys from the single-read-port
// memory, one key per cycle from the head, and decides at the first duplicate or last key. Each
// item gives exactly one result, shown on the o_ result ports for one cycle with o_valid high,
// in the cycle after the decision; busy is already low in that cycle. The receiver cannot stall,
// so results must be taken as they appear. Memory contents need no clearing after reset.
module unique_key_fifo #(
    parameter int DEPTH = ukf_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic signed [ukf_pkg::KEY_W-1:0]  i_in_key,
    input  logic signed [ukf_pkg::DATA_W-1:0] i_in_data,
    output logic                              o_valid,
    output logic [ukf_pkg::STAT_W-1:0]        o_status,
    output logic signed [ukf_pkg::KEY_W-1:0]  o_out_key,
    output logic signed [ukf_pkg::DATA_W-1:0] o_out_data,
    output logic [ukf_pkg::OCC_W-1:0]         o_occupancy
);
    import ukf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Control state
    t_state           r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_rd_cnt, n_rd_cnt;
    logic             r_valid, n_valid;

    // Payload registers
    logic [KEY_W-1:0]  r_key, n_key;
    logic [DATA_W-1:0] r_data, n_data;
    t_status           r_status, n_status;
    logic [KEY_W-1:0]  r_out_key, n_out_key;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    logic [OCC_W-1:0]  r_occ;

    // Memory port signals
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [KEY_W-1:0]  rd_key;
    logic [DATA_W-1:0] rd_data;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        ring_next = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    ukf_kv_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[WORD_W-1 -: KEY_W];
    assign rd_data = ram_rdata[DATA_W-1:0];

    // Decide the next state, drive the memory and build the result word
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_rd_ptr   = r_rd_ptr;
        n_rd_cnt   = r_rd_cnt;
        n_key      = r_key;
        n_data     = r_data;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_out_key  = '0;
        n_out_data = '0;
        ram_we     = 1'b0;
        ram_waddr  = r_tail;
        ram_wdata  = {r_key, r_data};
        ram_raddr  = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key  = i_in_key;
                    n_data = i_in_data;
                    if (i_mode == MODE_DEQ) begin
                        if (r_count == '0) begin
                            n_valid  = 1'b1;
                            n_status = ST_UNDER;
                        end else begin
                            n_state = S_DEQ;
                        end
                    end else if (r_count == '0) begin
                        ram_we    = 1'b1;
                        ram_wdata = {i_in_key, i_in_data};
                        n_tail    = ring_next(r_tail);
                        n_count   = r_count + CW'(1);
                        n_valid   = 1'b1;
                        n_status  = ST_ENQ;
                    end else begin
                        // Head key is being read now; continue from the next entry
                        n_state  = S_SCAN;
                        n_rd_ptr = ring_next(r_head);
                        n_rd_cnt = CW'(1);
                    end
                end
            end
            S_SCAN: begin
                ram_raddr = r_rd_ptr;
                if (rd_key == r_key) begin
                    n_valid  = 1'b1;
                    n_status = ST_DUP;
                    n_state  = S_IDLE;
                end else if (r_rd_cnt == r_count) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_count == CW'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        ram_we   = 1'b1;
                        n_tail   = ring_next(r_tail);
                        n_count  = r_count + CW'(1);
                        n_status = ST_ENQ;
                    end
                end else begin
                    n_rd_ptr = ring_next(r_rd_ptr);
                    n_rd_cnt = r_rd_cnt + CW'(1);
                end
            end
            S_DEQ: begin
                n_valid    = 1'b1;
                n_status   = ST_DEQ;
                n_out_key  = rd_key;
                n_out_data = rd_data;
                n_head     = ring_next(r_head);
                n_count    = r_count - CW'(1);
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_rd_ptr <= '0;
            r_rd_cnt <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_rd_ptr <= n_rd_ptr;
            r_rd_cnt <= n_rd_cnt;
            r_valid  <= n_valid;
        end
    end

    // Hold the latched item and the result word
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_data     <= n_data;
        r_status   <= n_status;
        r_out_key  <= n_out_key;
        r_out_data <= n_out_data;
        r_occ      <= OCC_W'(n_count);
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_key   = r_out_key;
    assign o_out_data  = r_out_data;
    assign o_occupancy = r_occ;

    // Occupancy never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // A result only appears once the controller is back in idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // An accepted enqueue into an empty queue gives an enqueued word next cycle
    a_enq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_ENQ && r_count == '0)
            |=> (o_valid && o_status == ST_ENQ && r_count == CW'(1)))
        else $error("enqueue into empty queue lost");

    // The scan never issues more reads than there are stored entries
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_cnt <= r_count && r_count != '0))
        else $error("key scan overran the queue");

endmodule

[bench/ukf_checker.sv]
// Result checker for the unique-key queue: mirrors the stored pairs and checks each result word.
`timescale 1ns / 100ps
module ukf_checker #(
    parameter int DEPTH = ukf_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic                              i_mode,
    input  logic signed [ukf_pkg::KEY_W-1:0]  i_in_key,
    input  logic signed [ukf_pkg::DATA_W-1:0] i_in_data,
    input  logic                              i_valid,
    input  logic [ukf_pkg::STAT_W-1:0]        i_status,
    input  logic signed [ukf_pkg::KEY_W-1:0]  i_out_key,
    input  logic signed [ukf_pkg::DATA_W-1:0] i_out_data,
    input  logic [ukf_pkg::OCC_W-1:0]         i_occupancy,
    output int                                o_err_count,
    output int                                o_pending
);
    import ukf_pkg::*;

    typedef struct {
        t_status           status;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        logic [OCC_W-1:0]  occ;
    } t_reply;

    // Mirror of the queue contents
    logic [KEY_W-1:0]  key_mirror  [DEPTH];
    logic [DATA_W-1:0] data_mirror [DEPTH];
    int                head_idx = 0;
    int                tail_idx = 0;
    int                stored   = 0;

    // Result words still owed by the block, oldest first
    t_reply            owed_replies [$];

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    // Apply one operation to the mirror and return the result word it should give
    function automatic t_reply apply_queue_op(input logic mode, input logic [KEY_W-1:0] key,
                                              input logic [DATA_W-1:0] data);
        t_reply r;
        bit     hit;
        int     idx;
        r.key  = '0;
        r.data = '0;
        hit    = 1'b0;
        if (mode == MODE_ENQ) begin
            // scan every stored key from the head; a duplicate wins over full
            idx = head_idx;
            for (int i = 0; i < stored; i++) begin
                if (key_mirror[idx] == key) hit = 1'b1;
                idx = (idx + 1) % DEPTH;
            end
            if (hit) begin
                r.status = ST_DUP;
            end else if (stored >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                key_mirror[tail_idx]  = key;
                data_mirror[tail_idx] = data;
                tail_idx = (tail_idx + 1) % DEPTH;
                stored++;
                r.status = ST_ENQ;
            end
        end else if (stored == 0) begin
            r.status = ST_UNDER;
        end else begin
            r.key    = key_mirror[head_idx];
            r.data   = data_mirror[head_idx];
            head_idx = (head_idx + 1) % DEPTH;
            stored--;
            r.status = ST_DEQ;
        end
        r.occ = OCC_W'(stored);
        return r;
    endfunction

    // Check result words against the oldest owed one, then log newly taken commands
    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            head_idx = 0;
            tail_idx = 0;
            stored   = 0;
            owed_replies.delete();
        end else begin
            if (i_valid) begin
                if (owed_replies.size() == 0) begin
                    $error("result word with nothing owed: status %0d", i_status);
                    o_err_count++;
                end else begin
                    want = owed_replies.pop_front();
                    if (i_status !== want.status) begin
                        $error("o_status: expected %0d, got %0d", want.status, i_status);
                        o_err_count++;
                    end
                    if (i_out_key !== want.key) begin
                        $error("o_out_key: expected %h, got %h", want.key, i_out_key);
                        o_err_count++;
                    end
                    if (i_out_data !== want.data) begin
                        $error("o_out_data: expected %h, got %h", want.data, i_out_data);
                        o_err_count++;
                    end
                    if (i_occupancy !== want.occ) begin
                        $error("o_occupancy: expected %0d, got %0d", want.occ, i_occupancy);
                        o_err_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                owed_replies.push_back(apply_queue_op(i_mode, i_in_key, i_in_data));
        end
        o_pending = owed_replies.size();
    end

endmodule

[bench/tb_top.sv]
// Top level of the unique-key queue bench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
    import ukf_pkg::*;

    localparam int RAND_ITEMS  = 1130;
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 400000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_mode = MODE_ENQ;
    logic signed [KEY_W-1:0]  i_in_key = '0;
    logic signed [DATA_W-1:0] i_in_data = '0;
    logic                     o_valid;
    logic [STAT_W-1:0]        o_status;
    logic signed [KEY_W-1:0]  o_out_key;
    logic signed [DATA_W-1:0] o_out_data;
    logic [OCC_W-1:0]         o_occupancy;
    int                       err_count;
    int                       pending;
    int                       cycle_cnt = 0;

    always #5 i_clk = ~i_clk;

    unique_key_fifo u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_in_key    (i_in_key),
        .i_in_data   (i_in_data),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_out_key   (o_out_key),
        .o_out_data  (o_out_data),
        .o_occupancy (o_occupancy)
    );

    ukf_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_mode      (i_mode),
        .i_in_key    (i_in_key),
        .i_in_data   (i_in_data),
        .i_valid     (o_valid),
        .i_status    (o_status),
        .i_out_key   (o_out_key),
        .i_out_data  (o_out_data),
        .i_occupancy (o_occupancy),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Present one command word and hold it until the block takes it
    task automatic send_word(input logic mode, input logic [KEY_W-1:0] key,
                             input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        start     <= 1'b1;
        i_mode    <= mode;
        i_in_key  <= key;
        i_in_data <= data;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start for a burst of cycles
    task automatic idle_gap(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    initial begin : stim
        logic [KEY_W-1:0] key_pool [24];
        logic [KEY_W-1:0] key;
        int               sent;
        int               phase_len;
        int               enq_pct;
        int               idle_pct;

        // Hold reset, then release it on a falling clock edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: underflow, extremes, duplicates, full, duplicate while full, dequeues
        send_word(MODE_DEQ, $urandom, $urandom);
        send_word(MODE_ENQ, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(MODE_ENQ, 32'h8000_0000, 32'h1234_5678);
        send_word(MODE_ENQ, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(MODE_ENQ, 32'h0000_0000, 32'h0000_0000);
        send_word(MODE_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 12; i++)
            send_word(MODE_ENQ, 32'(100 + i), $urandom);
        send_word(MODE_ENQ, 32'h5555_AAAA, $urandom);
        send_word(MODE_ENQ, 32'h7FFF_FFFF, $urandom);
        repeat (4) send_word(MODE_DEQ, $urandom, $urandom);

        // Key pool so that random enqueues often hit stored keys
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 24; i++) key_pool[i] = $urandom;

        // Random phases biased towards filling, draining or neither
        sent = 0;
        while (sent < RAND_ITEMS) begin
            phase_len = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0: enq_pct = 80;
                1: enq_pct = 25;
                default: enq_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 35;
            endcase
            repeat (phase_len) begin
                if (sent < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
                    idle_gap($urandom_range(1, 19));
                key = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 23)];
                send_word(($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ,
                          key, $urandom);
                sent++;
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Drain owed results, then let the clock run on before the verdict
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
